// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define FVN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define FVN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fvn_pkg.sv =====
// Types, constants and arithmetic helpers of the fractal value-noise heightmap.
package fvn_pkg;

  localparam int OCTAVES     = 6;
  localparam int PIX_W       = 12;
  localparam int SEED_W      = 32;
  localparam int SCALE_W     = 24;
  localparam int COORD_W     = 48;
  localparam int ACC_W       = 40;
  localparam int CELL_STAGES = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int HEIGHT_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SEED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd655;

  localparam logic [31:0] HASH_Y_MUL  = 32'd57;
  localparam logic [31:0] SEED_MUL    = 32'd131;
  localparam logic [31:0] HASH_MUL    = 32'd15731;
  localparam logic [31:0] HASH_ADD1   = 32'd789221;
  localparam logic [31:0] HASH_ADD2   = 32'd1376312589;

  typedef struct packed {
    logic                    valid;
    logic [COORD_W-1:0]      x;
    logic [COORD_W-1:0]      y;
    logic signed [ACC_W-1:0] acc;
  } cell_bus_t;

  function automatic logic [31:0] hash_pre(input logic [31:0] x, input logic [31:0] y,
                                           input logic [31:0] s131);
    logic [31:0] n;
    n = x + 32'(y * HASH_Y_MUL) + s131;
    return (n << 13) ^ n;
  endfunction

  function automatic logic [19:0] fade_p(input logic [15:0] t, input logic [31:0] t2);
    logic [39:0] s;
    s = 40'(t2) * 40'd6 + (40'd10 << 32) - 40'(t) * 40'd983040 + 40'd32768;
    return s[35:16];
  endfunction

  function automatic logic [32:0] fade_c(input logic [47:0] t3);
    logic [48:0] s;
    s = 49'(t3) + 49'd32768;
    return s[48:16];
  endfunction

  function automatic logic [16:0] fade_f(input logic [32:0] c, input logic [19:0] p);
    logic [52:0] s;
    s = 53'(c) * 53'(p) + 53'h80000000;
    return s[48:32];
  endfunction

  function automatic logic signed [33:0] lerp(input logic signed [33:0] a,
                                              input logic signed [33:0] b,
                                              input logic [16:0] f);
    logic signed [34:0] d;
    logic signed [52:0] pr;
    logic signed [52:0] sh;
    d  = 35'(b) - 35'(a);
    pr = 53'(d) * 53'($signed({1'b0, f})) + 53'sd32768;
    sh = pr >>> 16;
    return a + 34'(sh);
  endfunction

endpackage

// ===== rtl/fvn_cell.sv =====
// One octave cell: hashes the lattice corners, fades, blends and folds into the sum.
module fvn_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic [31:0]         seed131_i,
  input  fvn_pkg::cell_bus_t  bus_i,
  output fvn_pkg::cell_bus_t  bus_o
);

  localparam int S = fvn_pkg::CELL_STAGES;

  logic [S-1:0] valid_q;
  logic [fvn_pkg::COORD_W-1:0] xd_q [S];
  logic [fvn_pkg::COORD_W-1:0] yd_q [S];
  logic signed [fvn_pkg::ACC_W-1:0] accd_q [S-1];

  logic [31:0] x0, y0, x1, y1;
  logic [15:0] tx, ty;
  logic [31:0] n1_d [4];

  logic [31:0] n1_q [4];
  logic [15:0] tx1_q, ty1_q;
  logic [31:0] tx2_1_q, ty2_1_q;
  logic [31:0] n2_q [4];
  logic [31:0] nn2_q [4];
  logic [47:0] tx3_2_q, ty3_2_q;
  logic [19:0] px2_q, py2_q;
  logic [31:0] n3_q [4];
  logic [31:0] q3_q [4];
  logic [32:0] cx3_q, cy3_q;
  logic [19:0] px3_q, py3_q;
  logic signed [31:0] v4_q [4];
  logic [16:0] fx4_q, fy4_q;
  logic signed [33:0] top5_q, bot5_q;
  logic [16:0] fy5_q;
  logic signed [fvn_pkg::ACC_W-1:0] acc6_q;
  logic signed [33:0] res6;

  always_comb begin
    x0 = bus_i.x[47:16];
    y0 = bus_i.y[47:16];
    x1 = x0 + 32'd1;
    y1 = y0 + 32'd1;
    tx = bus_i.x[15:0];
    ty = bus_i.y[15:0];
    n1_d[0] = fvn_pkg::hash_pre(x0, y0, seed131_i);
    n1_d[1] = fvn_pkg::hash_pre(x1, y0, seed131_i);
    n1_d[2] = fvn_pkg::hash_pre(x0, y1, seed131_i);
    n1_d[3] = fvn_pkg::hash_pre(x1, y1, seed131_i);
  end

  assign res6 = fvn_pkg::lerp(top5_q, bot5_q, fy5_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[S-2:0], bus_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xd_q[0]   <= bus_i.x;
      yd_q[0]   <= bus_i.y;
      accd_q[0] <= bus_i.acc;
      for (int i = 1; i < S; i++) begin
        xd_q[i] <= xd_q[i-1];
        yd_q[i] <= yd_q[i-1];
      end
      for (int i = 1; i < S - 1; i++) begin
        accd_q[i] <= accd_q[i-1];
      end
      for (int k = 0; k < 4; k++) begin
        n1_q[k]  <= n1_d[k];
        n2_q[k]  <= n1_q[k];
        nn2_q[k] <= 32'(n1_q[k] * n1_q[k]);
        n3_q[k]  <= n2_q[k];
        q3_q[k]  <= 32'(nn2_q[k] * fvn_pkg::HASH_MUL) + fvn_pkg::HASH_ADD1;
        v4_q[k]  <= 32'sd1073741824
                  - $signed({1'b0, 31'(32'(n3_q[k] * q3_q[k]) + fvn_pkg::HASH_ADD2)});
      end
      tx1_q   <= tx;
      ty1_q   <= ty;
      tx2_1_q <= 32'(tx) * 32'(tx);
      ty2_1_q <= 32'(ty) * 32'(ty);
      tx3_2_q <= 48'(tx2_1_q) * 48'(tx1_q);
      ty3_2_q <= 48'(ty2_1_q) * 48'(ty1_q);
      px2_q   <= fvn_pkg::fade_p(tx1_q, tx2_1_q);
      py2_q   <= fvn_pkg::fade_p(ty1_q, ty2_1_q);
      cx3_q   <= fvn_pkg::fade_c(tx3_2_q);
      cy3_q   <= fvn_pkg::fade_c(ty3_2_q);
      px3_q   <= px2_q;
      py3_q   <= py2_q;
      fx4_q   <= fvn_pkg::fade_f(cx3_q, px3_q);
      fy4_q   <= fvn_pkg::fade_f(cy3_q, py3_q);
      top5_q  <= fvn_pkg::lerp(34'(v4_q[0]), 34'(v4_q[1]), fx4_q);
      bot5_q  <= fvn_pkg::lerp(34'(v4_q[2]), 34'(v4_q[3]), fx4_q);
      fy5_q   <= fy4_q;
      acc6_q  <= (accd_q[S-2] <<< 1) + fvn_pkg::ACC_W'(res6);
    end
  end

  always_comb begin
    bus_o.valid = valid_q[S-1];
    bus_o.x     = {xd_q[S-1][fvn_pkg::COORD_W-2:0], 1'b0};
    bus_o.y     = {yd_q[S-1][fvn_pkg::COORD_W-2:0], 1'b0};
    bus_o.acc   = acc6_q;
  end

endmodule

// ===== rtl/fvn_norm.sv =====
// Normalizer: divides the weighted octave sum by 63, rounding half away from zero.
module fvn_norm (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  fvn_pkg::cell_bus_t               bus_i,
  output logic                             valid_o,
  output logic [fvn_pkg::HEIGHT_W-1:0]     height_o
);

  logic [4:0]  valid_q;
  logic [37:0] x1_q, x2_q, x3_q, x4_q;
  logic [4:0]  neg_q;
  logic [43:0] y2_q;
  logic [55:0] y3_q;
  logic [31:0] qe4_q;
  logic [31:0] height_q;

  logic [37:0] mag;
  logic [79:0] y4;
  logic [39:0] rem;
  logic [31:0] qc;

  always_comb begin
    mag = bus_i.acc[fvn_pkg::ACC_W-1] ? 38'(-bus_i.acc) : 38'(bus_i.acc);
    y4  = (80'(y3_q) << 24) + 80'(y3_q);
    rem = 40'(x4_q) - ((40'(qe4_q) << 6) - 40'(qe4_q));
    qc  = (rem >= 40'd63) ? qe4_q + 32'd1 : qe4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[3:0], bus_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q     <= mag + 38'd31;
      neg_q    <= {neg_q[3:0], bus_i.acc[fvn_pkg::ACC_W-1]};
      y2_q     <= (44'(x1_q) << 6) + 44'(x1_q);
      x2_q     <= x1_q;
      y3_q     <= (56'(y2_q) << 12) + 56'(y2_q);
      x3_q     <= x2_q;
      qe4_q    <= y4[79:48];
      x4_q     <= x3_q;
      height_q <= neg_q[3] ? -qc : qc;
    end
  end

  assign valid_o  = valid_q[4];
  assign height_o = height_q;

endmodule

// ===== rtl/fractal_value_noise_heightmap.sv =====
// Fractal value-noise heightmap top level: stream ports, registers and the octave chain.
// Takes one pixel per cycle unless the output stalls. A register forms pixel times
// scale, each of the six octave cells is six stages deep, and the divide by 63 takes
// five more stages, the last one being the output register. The whole pipeline
// advances together, so while a result waits at the output with tready low, no new
// pixel is taken. Registers may only be written while no pixel is in flight.
module fractal_value_noise_heightmap (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [fvn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fvn_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [23:0]                        s_axis_tdata_i,  // pixel_x, pixel_y
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [31:0]                        m_axis_tdata_o   // height
);

  logic                          en;
  logic [31:0]                   seed131_q;
  logic [fvn_pkg::SCALE_W-1:0]   scale_q;
  logic                          v0_q;
  logic [fvn_pkg::COORD_W-1:0]   bx_q, by_q;
  fvn_pkg::cell_bus_t            bus [fvn_pkg::OCTAVES + 1];

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed131_q <= '0;
      scale_q   <= fvn_pkg::SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fvn_pkg::REG_SEED:  seed131_q <= 32'(cfg_data_i * fvn_pkg::SEED_MUL);
        fvn_pkg::REG_SCALE: scale_q   <= cfg_data_i[fvn_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q <= fvn_pkg::COORD_W'(s_axis_tdata_i[11:0]) * fvn_pkg::COORD_W'(scale_q);
      by_q <= fvn_pkg::COORD_W'(s_axis_tdata_i[23:12]) * fvn_pkg::COORD_W'(scale_q);
    end
  end

  always_comb begin
    bus[0].valid = v0_q;
    bus[0].x     = bx_q;
    bus[0].y     = by_q;
    bus[0].acc   = '0;
  end

  for (genvar g = 0; g < fvn_pkg::OCTAVES; g++) begin : g_cell
    fvn_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .seed131_i (seed131_q),
      .bus_i     (bus[g]),
      .bus_o     (bus[g+1])
    );
  end

  fvn_norm u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .bus_i    (bus[fvn_pkg::OCTAVES]),
    .valid_o  (m_axis_tvalid_o),
    .height_o (m_axis_tdata_o)
  );

endmodule

// ===== rtl/fvn_checker.sv =====
// Port-level checker for the heightmap block, bound to the top level.
`include "assert_macros.svh"

module fvn_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [fvn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [23:0]                    s_axis_tdata_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [31:0]                    m_axis_tdata_o
);

  `FVN_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "Stalled result changed.")
  `FVN_ASSERT_NOW(a_ready_when_empty, !m_axis_tvalid_o, s_axis_tready_o, "Input blocked with empty output.")
  `FVN_ASSERT_NOW(a_ready_when_taken, m_axis_tvalid_o && m_axis_tready_i, s_axis_tready_o, "Input blocked while result is taken.")
  `FVN_ASSERT_NOW(a_height_range, m_axis_tvalid_o, ($signed(m_axis_tdata_o) <= 32'sd1073741824) && ($signed(m_axis_tdata_o) >= -32'sd1073741824), "Height out of range.")

endmodule

bind fractal_value_noise_heightmap fvn_checker u_fvn_checker (.*);

// ===== sim/fractal_value_noise_heightmap_tb.sv =====
// Self-checking testbench of the fractal value-noise heightmap stream block.
module fractal_value_noise_heightmap_tb;

  localparam logic [fvn_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [fvn_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam int IDLE_LIMIT = 4000;

  class height_scoreboard;
    logic [fvn_pkg::SEED_W-1:0]  seed;
    logic [fvn_pkg::SCALE_W-1:0] scale;
    logic [31:0]                 heights_due[$];
    int                          mismatches;
    int                          checked;

    function new();
      seed = '0;
      scale = fvn_pkg::SCALE_RESET;
    endfunction

    function void write_reg(logic [fvn_pkg::CFG_IDX_W-1:0] idx,
                            logic [fvn_pkg::CFG_DATA_W-1:0] data);
      if (idx == fvn_pkg::REG_SEED) seed = data;
      else if (idx == fvn_pkg::REG_SCALE) scale = data[fvn_pkg::SCALE_W-1:0];
    endfunction

    function longint corner_value(logic [31:0] x, logic [31:0] y);
      logic [31:0] n;
      logic [31:0] m;
      n = x + y * 32'd57 + seed * 32'd131;
      n = (n << 13) ^ n;
      m = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
      return 64'sd1073741824 - longint'({32'b0, m});
    endfunction

    function longint unsigned smooth16(longint unsigned t);
      longint unsigned p;
      longint unsigned c;
      p = (64'd6 * t * t + (64'd10 << 32) - 64'd15 * t * 64'd65536 + 64'd32768) >> 16;
      c = (t * t * t + 64'd32768) >> 16;
      return (c * p + 64'h80000000) >> 32;
    endfunction

    function longint blend(longint a, longint b, longint unsigned f);
      longint v;
      v = (b - a) * longint'(f) + 64'sd32768;
      return a + (v >>> 16);
    endfunction

    function longint octave_noise(longint unsigned sx, longint unsigned sy);
      logic [31:0] x0;
      logic [31:0] y0;
      longint unsigned fx;
      longint unsigned fy;
      longint top;
      longint bot;
      x0 = sx[47:16];
      y0 = sy[47:16];
      fx = smooth16(sx & 64'hffff);
      fy = smooth16(sy & 64'hffff);
      top = blend(corner_value(x0, y0), corner_value(x0 + 32'd1, y0), fx);
      bot = blend(corner_value(x0, y0 + 32'd1), corner_value(x0 + 32'd1, y0 + 32'd1), fx);
      return blend(top, bot, fy);
    endfunction

    function void note_pixel(logic [fvn_pkg::PIX_W-1:0] px, logic [fvn_pkg::PIX_W-1:0] py);
      longint unsigned bx;
      longint unsigned by;
      longint sum;
      longint unsigned mag;
      longint unsigned q;
      longint res;
      bx = longint'(px) * longint'(scale);
      by = longint'(py) * longint'(scale);
      sum = 0;
      for (int o = 0; o < fvn_pkg::OCTAVES; o++)
        sum += octave_noise(bx << o, by << o) * (64'sd1 << (fvn_pkg::OCTAVES - 1 - o));
      mag = (sum < 0) ? -sum : sum;
      q = (mag + 64'd31) / 64'd63;
      res = (sum < 0) ? -longint'(q) : longint'(q);
      heights_due.push_back(res[31:0]);
    endfunction

    function void check_height(logic [31:0] actual);
      logic [31:0] want;
      checked++;
      if (heights_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected height %h", actual);
        return;
      end
      want = heights_due.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10) $display("height mismatch: expected %h, got %h", want, actual);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fvn_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [fvn_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  height_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int settings_run = 0;

  fractal_value_noise_heightmap dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o)
      sb.note_pixel(s_axis_tdata_i[11:0], s_axis_tdata_i[23:12]);
    if (m_axis_tvalid_o && m_axis_tready_i) sb.check_height(m_axis_tdata_o);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    static int mode = 0;
    static int run_left = 0;
    if (run_left == 0) begin
      mode = $urandom_range(0, 3);
      run_left = $urandom_range(5, 60);
    end
    run_left--;
    unique case (mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= $urandom_range(0, 1);
      2: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_pixel(logic [fvn_pkg::PIX_W-1:0] px, logic [fvn_pkg::PIX_W-1:0] py);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {py, px};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.heights_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [fvn_pkg::CFG_IDX_W-1:0] idx,
                           logic [fvn_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++)
      send_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
  endtask

  initial begin
    logic [fvn_pkg::CFG_DATA_W-1:0] seeds[6];
    logic [fvn_pkg::CFG_DATA_W-1:0] scales[6];
    seeds = '{32'd0, 32'hffffffff, 32'd0, $urandom(), $urandom(), 32'h80000001};
    scales = '{32'd655, 32'h00ffffff, 32'd0, $urandom_range(0, 24'hffffff),
               $urandom_range(1, 4000), 32'h00010000};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'haaa, 12'h555);
    send_pixel(12'h555, 12'haaa);
    send_pixel(12'd1, 12'd2048);
    drain();
    write_reg(fvn_pkg::REG_SEED, 32'hffffffff);
    write_reg(fvn_pkg::REG_SCALE, 32'hffffffff);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd1);
    send_pixel(12'd2048, 12'd4095);
    drain();
    write_reg(REG_SPARE_A, 32'h12345678);
    write_reg(REG_SPARE_B, 32'hdeadbeef);
    send_pixel(12'd100, 12'd200);
    send_pixel(12'd4095, 12'd1);
    drain();

    for (int k = 0; k < 6; k++) begin
      write_reg(fvn_pkg::REG_SEED, seeds[k]);
      write_reg(fvn_pkg::REG_SCALE, scales[k]);
      settings_run++;
      random_pixels(290);
      drain();
    end

    repeat (50) @(posedge clk_i);
    $display("checked %0d heights over %0d register settings plus directed corners",
             sb.checked, settings_run);
    if (sb.mismatches == 0 && sb.heights_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d heights outstanding", sb.mismatches,
               sb.heights_due.size());
      $display("status: fail");
    end
    $finish;
  end
endmodule
